>>> rtl/sorted_state_rank_unrank_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted state rank / unrank block
// Clocked on aclk and disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_STATE_RANK_UNRANK_DEFINES_SVH
`define SORTED_STATE_RANK_UNRANK_DEFINES_SVH

// Same-cycle implication
`define SSRR_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ssrr check failed");

// Next-cycle implication
`define SSRR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ssrr check failed");

`endif

>>> rtl/ssrr_pkg.sv
// ---------------------------------------------------------------------------
// ssrr_pkg
// Shared constants, types and helpers of the sorted state rank / unrank block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssrr_pkg;

    localparam int MAX_FIRMS      = 10;
    localparam int TABLE_DEPTH_DEF = 512;
    localparam int CODE_W         = 32;
    // compare-subtract steps of the address reduction; covers values below 32 * depth
    localparam int RED_STEPS      = 5;

    localparam logic [1:0] MODE_TABLE  = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [1:0] CFG_FIRM_COUNT   = 2'd0;
    localparam logic [1:0] CFG_LEVEL_COUNT  = 2'd1;
    localparam logic [1:0] CFG_COMMON_COUNT = 2'd2;

    localparam logic KIND_CODE = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [3:0]        position;
        logic [4:0]        level;
        logic [CODE_W-1:0] code;
        logic              last;
    } ssrr_result_t;

    typedef struct packed {
        logic              done;
        logic [CODE_W-1:0] quot;
        logic [4:0]        rem;
    } ssrr_div_res_t;

    // Reduce a nonnegative value below 2048 modulo depth (64..4096).
    function automatic logic [11:0] tbl_reduce(input logic [10:0] x, input logic [12:0] depth);
        logic [16:0] r;
        logic [16:0] d;
        r = {6'b0, x};
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            d = {4'b0, depth} << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[11:0];
    endfunction

endpackage

>>> rtl/sorted_state_rank_unrank.sv
// ---------------------------------------------------------------------------
// sorted_state_rank_unrank
// Rank / unrank of sorted state tuples through a loaded binomial table.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (s_valid / s_ready) carry a mode: table write, encode element
//   or decode code. The block works on one word at a time; s_ready is high
//   only while the control sequencer is idle.
//   Table write: taken while idle, no result.
//   Encode element: the common index is stored while idle; a firm element
//   passes address multiply, modulo reduction, table read and accumulate.
//   The last element then scales the sum and sends one code word.
//   Decode: the bit-serial divider runs first, then the common index word
//   is sent, then per firm one element word after a walk over the levels,
//   bound by the one table read port: each level step is one read and one
//   compare.
//   Results go through a one-word output register, so a new input word is
//   taken while a finished result still waits; a stalled receiver holds the
//   sequencer only when it has another word to send.
//   Reset clears control state and config (firms 2, levels 1, commons 1);
//   the table holds garbage until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_state_rank_unrank #(
    parameter int TABLE_DEPTH = ssrr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [8:0]  s_table_addr,
    input  logic [31:0] s_table_word,
    input  logic [4:0]  s_level,
    input  logic        s_elem_last,
    input  logic [31:0] s_state_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [3:0]  m_position,
    output logic [4:0]  m_out_level,
    output logic [31:0] m_out_code,
    output logic        m_out_last
);
    import ssrr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENC_RED,
        ST_ENC_RD,
        ST_ENC_ACC,
        ST_ENC_MULC,
        ST_ENC_EMIT,
        ST_DEC_DIV,
        ST_DEC_EMIT0,
        ST_DEC_START,
        ST_DEC_RD1,
        ST_DEC_CUR,
        ST_DEC_RDN,
        ST_DEC_CMP,
        ST_DEC_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [3:0] firm_count_reg;
    logic [4:0] level_count_reg;
    logic [4:0] common_count_reg;

    // encode progress
    logic [31:0] rank_sum_reg;
    logic [4:0]  common_hold_reg;
    logic [3:0]  elem_idx_reg;
    logic        enc_last_reg;
    logic signed [12:0] prod_reg;
    logic [31:0] scaled_reg;

    // decode walk
    logic [31:0]   j_reg;
    logic [31:0]   cur_reg;
    logic [4:0]    v_reg;
    logic [3:0]    n_reg;
    logic [4:0]    dcom_reg;
    logic [AW-1:0] addr_reg;

    logic [3:0]  eff_f;
    logic [4:0]  eff_c;
    logic [5:0]  stride1;
    logic        accept;

    logic signed [5:0]  lvl_m1;
    logic signed [12:0] enc_prod;
    logic signed [13:0] wrap_sum;
    logic [AW-1:0]      enc_addr;
    logic [AW:0]        step_sum;
    logic [AW-1:0]      addr_step;

    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic          tbl_re;
    logic [31:0]   tbl_rdata;

    logic          div_start;
    ssrr_div_res_t div_res;

    logic          out_load;
    logic          slot_free;
    ssrr_result_t  out_word;

    assign eff_f   = ({1'b0, firm_count_reg} > 5'(MAX_FIRMS)) ? 4'(MAX_FIRMS) : firm_count_reg;
    assign eff_c   = (common_count_reg == 5'd0) ? 5'd1 : common_count_reg;
    // row stride plus one: entry (v, n) sits at (v - 1) * stride1 + n - 1
    assign stride1 = 6'({2'b0, eff_f} + {1'b0, level_count_reg} + 6'd2);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign tbl_we    = accept && (s_mode == MODE_TABLE);
    assign tbl_waddr = AW'(tbl_reduce({2'b0, s_table_addr}, 13'(TABLE_DEPTH)));
    assign tbl_re    = (state_reg == ST_ENC_RD) || (state_reg == ST_DEC_RD1) ||
                       (state_reg == ST_DEC_RDN);
    assign div_start = accept && (s_mode == MODE_DECODE);

    always_comb begin
        lvl_m1   = $signed({1'b0, s_level}) - 6'sd1;
        enc_prod = lvl_m1 * $signed({1'b0, stride1});
        enc_prod = enc_prod + $signed({9'b0, elem_idx_reg}) - 13'sd1;
    end

    // a negative offset only comes from level zero and lands below the depth
    always_comb begin
        wrap_sum = {prod_reg[12], prod_reg} + 14'(TABLE_DEPTH);
        if (prod_reg[12]) begin
            enc_addr = AW'(wrap_sum);
        end else begin
            enc_addr = AW'(tbl_reduce(prod_reg[10:0], 13'(TABLE_DEPTH)));
        end
    end

    // advance one level: add stride1 and wrap once
    always_comb begin
        step_sum = {1'b0, addr_reg} + (AW + 1)'(stride1);
        if (step_sum >= (AW + 1)'(TABLE_DEPTH)) begin
            step_sum = step_sum - (AW + 1)'(TABLE_DEPTH);
        end
        addr_step = step_sum[AW-1:0];
    end

    always_comb begin
        out_load = 1'b0;
        out_word = '0;
        case (state_reg)
            ST_ENC_EMIT: begin
                out_load      = slot_free;
                out_word.kind = KIND_CODE;
                out_word.code = scaled_reg + {27'b0, common_hold_reg} - 32'd1;
                out_word.last = 1'b1;
            end
            ST_DEC_EMIT0: begin
                out_load       = slot_free;
                out_word.kind  = KIND_ELEM;
                out_word.level = dcom_reg;
                out_word.last  = (eff_f == 4'd0);
            end
            ST_DEC_EMIT: begin
                out_load          = slot_free;
                out_word.kind     = KIND_ELEM;
                out_word.position = n_reg;
                out_word.level    = v_reg;
                out_word.last     = (n_reg == 4'd1);
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            firm_count_reg   <= 4'd2;
            level_count_reg  <= 5'd1;
            common_count_reg <= 5'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FIRM_COUNT:   firm_count_reg   <= cfg_data[3:0];
                CFG_LEVEL_COUNT:  level_count_reg  <= cfg_data;
                CFG_COMMON_COUNT: common_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rank_sum_reg    <= '0;
            common_hold_reg <= '0;
            elem_idx_reg    <= '0;
            enc_last_reg    <= 1'b0;
            n_reg           <= '0;
            v_reg           <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_mode == MODE_ENCODE)) begin
                        enc_last_reg <= s_elem_last;
                        if (elem_idx_reg == 4'd0) begin
                            common_hold_reg <= s_level;
                        end
                        if (elem_idx_reg != 4'd15) begin
                            elem_idx_reg <= elem_idx_reg + 4'd1;
                        end
                        if ((elem_idx_reg != 4'd0) && (elem_idx_reg <= eff_f)) begin
                            prod_reg  <= enc_prod;
                            state_reg <= ST_ENC_RED;
                        end else if (s_elem_last) begin
                            state_reg <= ST_ENC_MULC;
                        end
                    end else if (div_start) begin
                        state_reg <= ST_DEC_DIV;
                    end
                end
                ST_ENC_RED: begin
                    addr_reg  <= enc_addr;
                    state_reg <= ST_ENC_RD;
                end
                ST_ENC_RD: begin
                    state_reg <= ST_ENC_ACC;
                end
                ST_ENC_ACC: begin
                    rank_sum_reg <= rank_sum_reg + tbl_rdata;
                    state_reg    <= enc_last_reg ? ST_ENC_MULC : ST_IDLE;
                end
                ST_ENC_MULC: begin
                    scaled_reg <= 32'(eff_c * rank_sum_reg);
                    state_reg  <= ST_ENC_EMIT;
                end
                ST_ENC_EMIT: begin
                    if (slot_free) begin
                        rank_sum_reg <= '0;
                        elem_idx_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_DEC_DIV: begin
                    if (div_res.done) begin
                        j_reg     <= div_res.quot;
                        dcom_reg  <= div_res.rem + 5'd1;
                        state_reg <= ST_DEC_EMIT0;
                    end
                end
                ST_DEC_EMIT0: begin
                    if (slot_free) begin
                        n_reg     <= eff_f;
                        state_reg <= (eff_f == 4'd0) ? ST_IDLE : ST_DEC_START;
                    end
                end
                ST_DEC_START: begin
                    addr_reg  <= AW'(n_reg - 4'd1);
                    v_reg     <= 5'd1;
                    state_reg <= ST_DEC_RD1;
                end
                ST_DEC_RD1: begin
                    state_reg <= ST_DEC_CUR;
                end
                ST_DEC_CUR: begin
                    cur_reg   <= tbl_rdata;
                    addr_reg  <= addr_step;
                    state_reg <= ST_DEC_RDN;
                end
                ST_DEC_RDN: begin
                    state_reg <= ST_DEC_CMP;
                end
                ST_DEC_CMP: begin
                    if (tbl_rdata <= j_reg) begin
                        cur_reg <= tbl_rdata;
                        v_reg   <= v_reg + 5'd1;
                        if (v_reg == 5'd30) begin
                            state_reg <= ST_DEC_EMIT;
                        end else begin
                            addr_reg  <= addr_step;
                            state_reg <= ST_DEC_RDN;
                        end
                    end else begin
                        state_reg <= ST_DEC_EMIT;
                    end
                end
                ST_DEC_EMIT: begin
                    if (slot_free) begin
                        j_reg <= j_reg - cur_reg;
                        if (n_reg == 4'd1) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            n_reg     <= n_reg - 4'd1;
                            state_reg <= ST_DEC_START;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ssrr_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (s_table_word),
        .rd_en   (tbl_re),
        .rd_addr (addr_reg),
        .rd_data (tbl_rdata)
    );

    ssrr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_state_code),
        .divisor  (eff_c),
        .res      (div_res)
    );

    ssrr_outreg u_outreg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .word        (out_word),
        .slot_free   (slot_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_position  (m_position),
        .m_out_level (m_out_level),
        .m_out_code  (m_out_code),
        .m_out_last  (m_out_last)
    );

endmodule

>>> rtl/ssrr_table.sv
// ---------------------------------------------------------------------------
// ssrr_table
// Binomial coefficient table: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrr_table #(
    parameter int DEPTH = ssrr_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    import ssrr_pkg::*;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/ssrr_div.sv
// ---------------------------------------------------------------------------
// ssrr_div
// Restoring divider: 32-bit code by 5-bit common count, one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ssrr_pkg::CODE_W-1:0] dividend,
    input  logic [4:0]                  divisor,
    output ssrr_pkg::ssrr_div_res_t     res
);
    import ssrr_pkg::*;

    localparam int CNT_W = $clog2(CODE_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CODE_W-1:0] quot_reg;
    logic [4:0]        rem_reg;
    logic [4:0]        dvs_reg;

    logic [5:0]        rem_sh;
    logic              q_bit;
    logic [4:0]        rem_next;
    logic [CODE_W-1:0] quot_next;

    always_comb begin
        rem_sh    = {rem_reg, quot_reg[CODE_W-1]};
        q_bit     = (rem_sh >= {1'b0, dvs_reg});
        rem_next  = q_bit ? 5'(rem_sh - {1'b0, dvs_reg}) : rem_sh[4:0];
        quot_next = {quot_reg[CODE_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CODE_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

>>> rtl/ssrr_outreg.sv
// ---------------------------------------------------------------------------
// ssrr_outreg
// Result output register: holds one word until the receiver takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrr_outreg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  ssrr_pkg::ssrr_result_t      word,
    output logic                        slot_free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [3:0]                  m_position,
    output logic [4:0]                  m_out_level,
    output logic [ssrr_pkg::CODE_W-1:0] m_out_code,
    output logic                        m_out_last
);
    import ssrr_pkg::*;

    logic         valid_reg;
    ssrr_result_t word_reg;

    // a word leaving this cycle frees the slot for the next one
    assign slot_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word;
        end
    end

    assign m_valid     = valid_reg;
    assign m_kind      = word_reg.kind;
    assign m_position  = word_reg.position;
    assign m_out_level = word_reg.level;
    assign m_out_code  = word_reg.code;
    assign m_out_last  = word_reg.last;

endmodule

>>> rtl/ssrr_checker.sv
// ---------------------------------------------------------------------------
// ssrr_checker
// Port-level checks of the rank / unrank block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_state_rank_unrank_defines.svh"

module ssrr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [1:0]  cfg_index,
    input logic [4:0]  cfg_data,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_mode,
    input logic [8:0]  s_table_addr,
    input logic [31:0] s_table_word,
    input logic [4:0]  s_level,
    input logic        s_elem_last,
    input logic [31:0] s_state_code,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [3:0]  m_position,
    input logic [4:0]  m_out_level,
    input logic [31:0] m_out_code,
    input logic        m_out_last
);
    import ssrr_pkg::*;

    // hold a stalled result word
    `SSRR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_position) && $stable(m_out_level) && $stable(m_out_code) && $stable(m_out_last))

    // an accepted decode word closes the input side
    `SSRR_ASSERT_NEXT(a_dec_busy, s_valid && s_ready && (s_mode == MODE_DECODE), !s_ready)

    // a table write never blocks the next word
    `SSRR_ASSERT_NEXT(a_tbl_ready, s_valid && s_ready && (s_mode == MODE_TABLE), s_ready)

    // a code word is always final and carries no element
    `SSRR_ASSERT_IMPLY(a_code_shape, m_valid && (m_kind == KIND_CODE), m_out_last && (m_position == 4'd0) && (m_out_level == 5'd0))

    // an element word carries no code
    `SSRR_ASSERT_IMPLY(a_elem_shape, m_valid && (m_kind == KIND_ELEM), m_out_code == 32'd0)

endmodule

bind sorted_state_rank_unrank ssrr_checker u_checker (.*);
